// ===== rtl/wt_pkg.sv =====
package wt_pkg;

  localparam int unsigned WATCH_SLOTS = 16;
  localparam int unsigned SLOT_W      = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
  localparam int unsigned FD_W        = 16;
  localparam int unsigned MASK_W      = 16;
  localparam int unsigned IDX_OUT_W   = 4;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_MOD     = 2'd1,
    OP_DEL     = 2'd2,
    OP_UNKNOWN = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOSPACE = 2'd2
  } status_e;

  // search token walking down the cell row
  typedef struct packed {
    logic              vld;
    logic [FD_W-1:0]   key;
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free;
    logic [SLOT_W-1:0] free_idx;
  } tok_t;

  // table update broadcast to all cells
  typedef struct packed {
    logic              en;
    op_e               kind;
    logic [SLOT_W-1:0] idx;
    logic [FD_W-1:0]   key;
    logic [MASK_W-1:0] mask;
  } cmt_t;

  function automatic logic [IDX_OUT_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+IDX_OUT_W-1:0] wide;
    wide = {{IDX_OUT_W{1'b0}}, idx};
    return wide[IDX_OUT_W-1:0];
  endfunction

endpackage

// ===== rtl/wt_if.sv =====
interface wt_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic signed [wt_pkg::FD_W-1:0]  target_fd;
  logic [wt_pkg::MASK_W-1:0]       event_mask;

  modport source (output valid, req_type, target_fd, event_mask, input ready);
  modport sink   (input valid, req_type, target_fd, event_mask, output ready);
endinterface

interface wt_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic [wt_pkg::IDX_OUT_W-1:0]     slot_index;

  modport source (output valid, status, slot_index, input ready);
  modport sink   (input valid, status, slot_index, output ready);
endinterface

// ===== rtl/wt_cell.sv =====
module wt_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [wt_pkg::SLOT_W-1:0]  idx_i,
  input  wt_pkg::tok_t               tok_i,
  input  wt_pkg::cmt_t               cmt_i,
  output wt_pkg::tok_t               tok_o
);
  import wt_pkg::*;

  logic              used_q;
  logic [FD_W-1:0]   key_q;
  logic [MASK_W-1:0] mask_q;
  tok_t              tok_d, tok_q;
  logic              sel;

  assign sel = cmt_i.en && (cmt_i.idx == idx_i);

  // first free slot and first matching slot win, later cells pass them on
  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld) begin
      if (!used_q) begin
        if (!tok_i.free) begin
          tok_d.free     = 1'b1;
          tok_d.free_idx = idx_i;
        end
      end else if (!tok_i.hit && (key_q == tok_i.key)) begin
        tok_d.hit     = 1'b1;
        tok_d.hit_idx = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      tok_q <= tok_d;
      if (sel) begin
        case (cmt_i.kind)
          OP_ADD:  used_q <= 1'b1;
          OP_DEL:  used_q <= 1'b0;
          default: used_q <= used_q;
        endcase
      end
    end
  end

  // contents are only looked at under the valid bit
  always_ff @(posedge clk_i) begin
    if (sel && (cmt_i.kind == OP_ADD)) begin
      key_q  <= cmt_i.key;
      mask_q <= cmt_i.mask;
    end else if (sel && (cmt_i.kind == OP_MOD)) begin
      mask_q <= cmt_i.mask;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/watch_table_add_modify_delete.sv =====
// one request at a time: a new request is taken only in the idle state
// the search token steps through the row of slot cells one cell per cycle
// the response register lets the next request in while a response beat waits
// reset clears all slot valid bits and control state; keys and masks in the slot cells are not cleared
module watch_table_add_modify_delete (
  input  logic     clk_i,
  input  logic     rst_ni,
  wt_req_if.sink   req_i,
  wt_rsp_if.source rsp_o
);
  import wt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DECIDE
  } state_e;

  state_e              state_q;
  op_e                 op_q;
  logic [FD_W-1:0]     fd_q;
  logic [MASK_W-1:0]   mask_q;
  tok_t                done_q;
  tok_t                head_tok;
  tok_t                chain [WATCH_SLOTS+1];
  logic [WATCH_SLOTS-1:0] tok_vld;
  cmt_t                cmt;
  logic                accept;
  logic                out_free;
  status_e             res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic                rsp_valid_q;
  status_e             rsp_status_q;
  logic [IDX_OUT_W-1:0] rsp_slot_q;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    head_tok     = '0;
    head_tok.vld = accept;
    head_tok.key = req_i.target_fd;
  end

  assign chain[0] = head_tok;

  for (genvar g = 0; g < WATCH_SLOTS; g++) begin : g_cell
    wt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (SLOT_W'(g)),
      .tok_i  (chain[g]),
      .cmt_i  (cmt),
      .tok_o  (chain[g+1])
    );
    assign tok_vld[g] = chain[g+1].vld;
  end

  // outcome of the finished search
  always_comb begin
    res_status = ST_INVALID;
    res_slot   = '0;
    cmt        = '0;
    cmt.kind   = op_q;
    cmt.key    = fd_q;
    cmt.mask   = mask_q;
    if (!fd_q[FD_W-1]) begin
      case (op_q) inside
        OP_ADD: begin
          if (done_q.hit) begin
            res_status = ST_INVALID;
          end else if (!done_q.free) begin
            res_status = ST_NOSPACE;
          end else begin
            res_status = ST_OK;
            res_slot   = done_q.free_idx;
          end
        end
        OP_MOD, OP_DEL: begin
          if (done_q.hit) begin
            res_status = ST_OK;
            res_slot   = done_q.hit_idx;
          end
        end
        default: res_status = ST_INVALID;
      endcase
    end
    cmt.idx = res_slot;
    cmt.en  = (state_q == S_DECIDE) && out_free && (res_status == ST_OK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= OP_ADD;
      fd_q         <= '0;
      mask_q       <= '0;
      done_q       <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_status_q <= ST_OK;
      rsp_slot_q   <= '0;
    end else begin
      // a beat taken this cycle is dropped unless a new one is loaded
      if (rsp_o.ready && !((state_q == S_DECIDE) && out_free)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= op_e'(req_i.req_type);
            fd_q    <= req_i.target_fd;
            mask_q  <= req_i.event_mask;
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          if (chain[WATCH_SLOTS].vld) begin
            done_q  <= chain[WATCH_SLOTS];
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            rsp_valid_q  <= 1'b1;
            rsp_status_q <= res_status;
            rsp_slot_q   <= slot_field(res_slot);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.slot_index = rsp_slot_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one search token in the cell row");

  a_tail_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[WATCH_SLOTS].vld |-> (state_q == S_WALK))
    else $error("search token left the row outside the walk state");

  a_rsp_from_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !$past(rsp_valid_q && !rsp_o.ready)) |-> $past(state_q == S_DECIDE))
    else $error("response loaded without a finished search");

  a_fail_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_status_q != ST_OK)) |-> (rsp_slot_q == '0))
    else $error("failed response carries a slot number");

  a_commit_idle_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmt.en |=> (state_q == S_IDLE) && rsp_valid_q)
    else $error("table update without a response");

endmodule
